@@ rtl/ahss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahss_pkg
// shared codes and widths for the arm homing and stall sequencer
// ----------------------------------------------------------------------------
package ahss_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int POS_W    = 32;
  localparam int TGT_W    = 16;
  localparam int DRIVE_W  = 8;
  localparam int TIMER_W  = 16;
  localparam int THR_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // arm mode codes
  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_HOMING = 2'd1;
  localparam logic [1:0] MODE_IDLE   = 2'd2;
  localparam logic [1:0] MODE_TWITCH = 2'd3;

  // drive mode codes
  localparam logic [1:0] DRIVE_NONE     = 2'd0;
  localparam logic [1:0] DRIVE_FIXED    = 2'd1;
  localparam logic [1:0] DRIVE_REGULATE = 2'd2;

  // item kinds
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_POSITION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_POSITION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOMING_DRIVE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TWITCH_TICKS    = 3'd5;

  // register reset values
  localparam logic [THR_W-1:0]   RST_STALL_THRESHOLD = 10'd200;
  localparam logic [TGT_W-1:0]   RST_HIGH_POSITION   = 16'hFDA8;  // -600
  localparam logic [TGT_W-1:0]   RST_LOW_POSITION    = 16'hF128;  // -3800
  localparam logic [DRIVE_W-1:0] RST_HOMING_DRIVE    = 8'd180;
  localparam logic [TIMER_W-1:0] RST_INIT_WAIT_TICKS = 16'd100;
  localparam logic [TIMER_W-1:0] RST_TWITCH_TICKS    = 16'd300;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

endpackage

@@ rtl/arm_homing_stall_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_homing_stall_sequencer
// encoder position counter, current window stall detector and arm mode
// sequencer (init wait, homing, idle, twitch up) that tells the regulator
// what to do on every tick
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | in_valid/in_stall  | op, encoder_b, current_sample,
//          |           |                    | pressure_switch, top_switch
//  result  | out       | out_valid/out_stall| arm_mode, drive_mode, fixed_drive,
//          |           |                    | target_position, position,
//          |           |                    | stall_flag
//  config  | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one item per cycle while in_stall is low: state and the result register update on
//  the edge that takes the transfer, so the result shows in the next cycle
//  in_stall rises only while a result is held and the result side stalls
//  rst is synchronous and restores registers, position, mode, window and timer
//  cfg_ready is always high; writes land on the next edge
//
module arm_homing_stall_sequencer #(
  parameter int AVG_WINDOW = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic                              encoder_b,
  input  logic [ahss_pkg::SAMPLE_W-1:0]     current_sample,
  input  logic                              pressure_switch,
  input  logic                              top_switch,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        arm_mode,
  output logic [1:0]                        drive_mode,
  output logic [ahss_pkg::DRIVE_W-1:0]      fixed_drive,
  output logic signed [ahss_pkg::TGT_W-1:0] target_position,
  output logic signed [ahss_pkg::POS_W-1:0] position,
  output logic                              stall_flag,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ahss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ahss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ahss_pkg::*;

  // window counter and sum widths; the sum never overflows for a full window
  localparam int CNT_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int SUM_W = ((AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 0) + SAMPLE_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_WINDOW - 1);

  // configuration registers
  logic [THR_W-1:0]   stall_threshold;
  logic [TGT_W-1:0]   high_position;
  logic [TGT_W-1:0]   low_position;
  logic [DRIVE_W-1:0] homing_drive;
  logic [TIMER_W-1:0] init_wait_ticks;
  logic [TIMER_W-1:0] twitch_ticks;

  // block state
  logic [POS_W-1:0]   arm_position, arm_position_next;
  logic [1:0]         mode, mode_next;
  logic [CNT_W-1:0]   window_count, window_count_next;
  logic [SUM_W-1:0]   window_sum, window_sum_next;
  logic [TIMER_W-1:0] state_timer, state_timer_next;

  // result values for the accepted item
  logic [1:0]         drive_next;
  logic [DRIVE_W-1:0] fixed_next;
  logic [TGT_W-1:0]   target_next;
  logic               stall_next;

  logic               in_take;
  logic [SUM_W-1:0]   sum_acc;
  logic [SUM_W-1:0]   thr_scaled;
  logic [TIMER_W-1:0] timer_inc;

  assign cfg_ready = 1'b1;

  // hold off new items only while the result register is full and stuck
  assign in_stall = out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;

  // floor(sum / N) >= thr  is the same as  sum >= thr * N
  assign thr_scaled = SUM_W'(stall_threshold * AVG_WINDOW);
  assign sum_acc    = window_sum + SUM_W'(current_sample);
  assign timer_inc  = (state_timer == TIMER_MAX) ? TIMER_MAX : state_timer + 1'b1;

  always_comb begin
    arm_position_next = arm_position;
    mode_next         = mode;
    window_count_next = window_count;
    window_sum_next   = window_sum;
    state_timer_next  = state_timer;
    drive_next        = DRIVE_NONE;
    fixed_next        = '0;
    target_next       = '0;
    stall_next        = 1'b0;

    if (op == OP_EDGE) begin
      // encoder B picks the count direction
      if (encoder_b) begin
        arm_position_next = arm_position + 1'b1;
      end else begin
        arm_position_next = arm_position - 1'b1;
      end
    end else begin
      // current window
      if (window_count >= CNT_LAST) begin
        window_count_next = '0;
        window_sum_next   = '0;
        if (sum_acc >= thr_scaled) begin
          stall_next = 1'b1;
          mode_next  = MODE_IDLE;
        end
      end else begin
        window_count_next = window_count + 1'b1;
        window_sum_next   = sum_acc;
      end

      // pressure wins over a stall and restarts the twitch span
      if (pressure_switch) begin
        mode_next        = MODE_TWITCH;
        state_timer_next = '0;
      end

      // mode sequencer, timer steps from the stored value; the twitch case handles a clear by pressure
      case (mode_next)
        MODE_INIT: begin
          if (timer_inc >= init_wait_ticks) begin
            state_timer_next = '0;
            mode_next        = MODE_HOMING;
          end else begin
            state_timer_next = timer_inc;
          end
        end
        MODE_HOMING: begin
          drive_next = DRIVE_FIXED;
          fixed_next = homing_drive;
          if (top_switch) begin
            arm_position_next = '0;
            state_timer_next  = '0;
            mode_next         = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          drive_next  = DRIVE_REGULATE;
          target_next = low_position;
        end
        default: begin
          drive_next  = DRIVE_REGULATE;
          target_next = high_position;
          // pressed this tick means the timer was just cleared
          if (pressure_switch) begin
            if (TIMER_W'(1) >= twitch_ticks) begin
              state_timer_next = '0;
              mode_next        = MODE_IDLE;
            end else begin
              state_timer_next = TIMER_W'(1);
            end
          end else if (timer_inc >= twitch_ticks) begin
            state_timer_next = '0;
            mode_next        = MODE_IDLE;
          end else begin
            state_timer_next = timer_inc;
          end
        end
      endcase
    end
  end

  // only the twitch case needs the cleared-by-pressure timer; pressure never leaves
  // the mode at init, so timer_inc from the stored value is correct there

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_threshold <= RST_STALL_THRESHOLD;
      high_position   <= RST_HIGH_POSITION;
      low_position    <= RST_LOW_POSITION;
      homing_drive    <= RST_HOMING_DRIVE;
      init_wait_ticks <= RST_INIT_WAIT_TICKS;
      twitch_ticks    <= RST_TWITCH_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STALL_THRESHOLD: stall_threshold <= cfg_data[THR_W-1:0];
        REG_HIGH_POSITION:   high_position   <= cfg_data[TGT_W-1:0];
        REG_LOW_POSITION:    low_position    <= cfg_data[TGT_W-1:0];
        REG_HOMING_DRIVE:    homing_drive    <= cfg_data[DRIVE_W-1:0];
        REG_INIT_WAIT_TICKS: init_wait_ticks <= cfg_data[TIMER_W-1:0];
        REG_TWITCH_TICKS:    twitch_ticks    <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_position <= '0;
      mode         <= MODE_INIT;
      window_count <= '0;
      window_sum   <= '0;
      state_timer  <= '0;
    end else if (in_take) begin
      arm_position <= arm_position_next;
      mode         <= mode_next;
      window_count <= window_count_next;
      window_sum   <= window_sum_next;
      state_timer  <= state_timer_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      arm_mode        <= mode_next;
      drive_mode      <= drive_next;
      fixed_drive     <= fixed_next;
      target_position <= target_next;
      position        <= arm_position_next;
      stall_flag      <= stall_next;
    end
  end

endmodule
